>>> src/bpe_pkg.sv
// Shared types and constants for the binomial prime exponent block.
package bpe_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FIELD_W       = 32;
    localparam int EXP_W         = 6;
    localparam int STAT_W        = 2;

    localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
    localparam logic [STAT_W-1:0] STAT_K_EXCEEDS_N = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_DIVISOR = 2'd2;

    // which Legendre sum is being formed
    typedef enum logic [1:0] {
        OPD_N  = 2'd0,
        OPD_K  = 2'd1,
        OPD_NK = 2'd2
    } operand_t;

    typedef struct packed {
        logic                load;       // capture the input word, clear the sum
        logic                ld_x;       // load the running dividend from an operand
        operand_t            sel;
        logic                div_start;
        logic                div_step;
        logic                accum;      // take the quotient, add or subtract it
        logic                write_out;
        logic [STAT_W-1:0]   res_stat;
    } bpe_cmd_t;

    typedef struct packed {
        logic k_gt_n;
        logic p_small;
        logic x_zero;
        logic div_last;
    } bpe_stat_t;

endpackage

>>> src/bpe_datapath.sv
// Datapath: operand registers, shared restoring divider and exponent accumulator.
module bpe_datapath #(
    parameter int WORD_BITS = bpe_pkg::WORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic [bpe_pkg::FIELD_W-1:0]   top,
    input  logic [bpe_pkg::FIELD_W-1:0]   choose,
    input  logic [bpe_pkg::FIELD_W-1:0]   prime,
    input  bpe_pkg::bpe_cmd_t             cmd,
    output bpe_pkg::bpe_stat_t            stat,
    output logic [bpe_pkg::EXP_W-1:0]     exponent,
    output logic [bpe_pkg::STAT_W-1:0]    status
);
    import bpe_pkg::*;

    localparam int CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    logic [WORD_BITS-1:0] n_reg;
    logic [WORD_BITS-1:0] k_reg;
    logic [WORD_BITS-1:0] p_reg;
    logic [WORD_BITS-1:0] x_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] quo_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [EXP_W-1:0]     acc_reg;
    logic [EXP_W-1:0]     exp_reg;
    logic [STAT_W-1:0]    stat_reg;

    logic [WORD_BITS-1:0] opd;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   diff;
    logic                 fits;

    always_comb
    begin
        case (cmd.sel)
            OPD_N:   opd = n_reg;
            OPD_K:   opd = k_reg;
            OPD_NK:  opd = n_reg - k_reg;
            default: opd = n_reg;
        endcase
    end

    // one quotient bit per cycle; remainder stays below p so no borrow means fit
    assign trial = {rem_reg, quo_reg[WORD_BITS-1]};
    assign diff  = trial - {1'b0, p_reg};
    assign fits  = ~diff[WORD_BITS];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg   <= WORD_BITS'(top);
            k_reg   <= WORD_BITS'(choose);
            p_reg   <= WORD_BITS'(prime);
            acc_reg <= '0;
        end
        if (cmd.ld_x)
        begin
            x_reg <= opd;
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= x_reg;
            cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= fits ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
            quo_reg <= {quo_reg[WORD_BITS-2:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.accum)
        begin
            x_reg <= quo_reg;
            if (cmd.sel == OPD_N)
            begin
                acc_reg <= acc_reg + quo_reg[EXP_W-1:0];
            end
            else
            begin
                acc_reg <= acc_reg - quo_reg[EXP_W-1:0];
            end
        end
        if (cmd.write_out)
        begin
            exp_reg  <= (cmd.res_stat == STAT_OK) ? acc_reg : '0;
            stat_reg <= cmd.res_stat;
        end
    end

    assign stat.k_gt_n   = k_reg > n_reg;
    assign stat.p_small  = p_reg < WORD_BITS'(2);
    assign stat.x_zero   = x_reg == '0;
    assign stat.div_last = cnt_reg == CNT_W'(WORD_BITS - 1);

    assign exponent = exp_reg;
    assign status   = stat_reg;

endmodule

>>> src/bpe_ctrl.sv
// Controller: sequences the three Legendre sums and the output word.
module bpe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  bpe_pkg::bpe_stat_t  stat,
    output bpe_pkg::bpe_cmd_t   cmd
);
    import bpe_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_TEST  = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_ACC   = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    operand_t            sel_reg, sel_next;
    logic [STAT_W-1:0]   res_reg, res_next;
    logic                out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        cmd.res_stat = res_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.k_gt_n)
                begin
                    res_next   = STAT_K_EXCEEDS_N;
                    state_next = ST_FIN;
                end
                else if (stat.p_small)
                begin
                    res_next   = STAT_BAD_DIVISOR;
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.ld_x   = 1'b1;
                    cmd.sel    = OPD_N;
                    sel_next   = OPD_N;
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (stat.x_zero)
                begin
                    case (sel_reg)
                        OPD_N:
                        begin
                            cmd.ld_x = 1'b1;
                            cmd.sel  = OPD_K;
                            sel_next = OPD_K;
                        end
                        OPD_K:
                        begin
                            cmd.ld_x = 1'b1;
                            cmd.sel  = OPD_NK;
                            sel_next = OPD_NK;
                        end
                        default:
                        begin
                            res_next   = STAT_OK;
                            state_next = ST_FIN;
                        end
                    endcase
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = ST_TEST;
            end
            ST_FIN:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.write_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.write_out | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= OPD_N;
            res_reg       <= STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> src/binomial_prime_exponent.sv
// From acceptance, a word with k above n or a prime below two goes straight to the output;
// otherwise the bit-serial divider runs once per base-p digit of n, k and n - k together
// (at most 3 * WORD_BITS digits), and the output is written after the last sum.
// One word at a time: the next is taken the cycle after the result enters the output
// register, so the block does not take a new word while one is in flight.
// Reset (rst_n, async, active low) clears the controller and output valid only.
module binomial_prime_exponent #(
    parameter int WORD_BITS = bpe_pkg::WORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bpe_pkg::FIELD_W-1:0]   top,
    input  logic [bpe_pkg::FIELD_W-1:0]   choose,
    input  logic [bpe_pkg::FIELD_W-1:0]   prime,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bpe_pkg::EXP_W-1:0]     exponent,
    output logic [bpe_pkg::STAT_W-1:0]    status
);
    import bpe_pkg::*;

    bpe_cmd_t  cmd;
    bpe_stat_t stat;

    bpe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bpe_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk      (clk),
        .top      (top),
        .choose   (choose),
        .prime    (prime),
        .cmd      (cmd),
        .stat     (stat),
        .exponent (exponent),
        .status   (status)
    );

`ifndef SYNTHESIS
    a_err_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> exponent == '0)
        else $error("error word carries nonzero exponent");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new word taken while one is in flight");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.ld_x, cmd.div_start, cmd.div_step, cmd.accum,
                  cmd.write_out}))
        else $error("conflicting datapath commands");
`endif

endmodule

>>> test/binomial_prime_exponent_test.sv
// Testbench for binomial_prime_exponent: corner table plus random words, checked by a Legendre-sum predictor.
module binomial_prime_exponent_test;
    import bpe_pkg::*;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int RANDOM_WORDS = 168;
    localparam int HOLD_AT      = 30;
    localparam int HOLD_CYCLES  = 8000;
    localparam int DRAIN_CYCLES = 3300;
    localparam int NUM_CORNERS  = 22;

    typedef struct packed {
        logic [EXP_W-1:0]  expo;
        logic [STAT_W-1:0] stat;
    } result_t;

    typedef struct packed {
        logic [FIELD_W-1:0] n;
        logic [FIELD_W-1:0] k;
        logic [FIELD_W-1:0] p;
        logic               known;
        result_t            want;
    } corner_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               out_ready = 1'b0;
    logic [FIELD_W-1:0] top       = '0;
    logic [FIELD_W-1:0] choose    = '0;
    logic [FIELD_W-1:0] prime     = '0;
    logic               in_ready;
    logic               out_valid;
    logic [EXP_W-1:0]   exponent;
    logic [STAT_W-1:0]  status;

    result_t     expected_results[$];
    int          mismatches   = 0;
    int          words_sent   = 0;
    int          results_seen = 0;
    int          cycles       = 0;
    int          send_idle    = 13;
    int          recv_idle    = 84;
    int unsigned small_primes[8] = '{2, 3, 5, 7, 11, 13, 31, 65521};
    corner_t     corners[NUM_CORNERS];

    binomial_prime_exponent dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // sum of floor(x / p^i), i >= 1; p is at least two
    function automatic logic [63:0] quotient_sum(input logic [63:0] x, input logic [63:0] p);
        logic [63:0] sum;
        sum = '0;
        while (x != 0)
        begin
            x   = x / p;
            sum = sum + x;
        end
        return sum;
    endfunction

    function automatic result_t legendre_exponent(input logic [FIELD_W-1:0] n,
                                                  input logic [FIELD_W-1:0] k,
                                                  input logic [FIELD_W-1:0] p);
        result_t     r;
        logic [63:0] e;
        if (k > n)
        begin
            r.expo = '0;
            r.stat = STAT_K_EXCEEDS_N;
        end
        else if (p < 2)
        begin
            r.expo = '0;
            r.stat = STAT_BAD_DIVISOR;
        end
        else
        begin
            e = quotient_sum(64'(n), 64'(p)) - quotient_sum(64'(k), 64'(p))
                - quotient_sum(64'(n - k), 64'(p));
            r.expo = e[EXP_W-1:0];
            r.stat = STAT_OK;
        end
        return r;
    endfunction

    task automatic offer_word(input logic [FIELD_W-1:0] n, input logic [FIELD_W-1:0] k,
                              input logic [FIELD_W-1:0] p, input result_t want);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        top      <= n;
        choose   <= k;
        prime    <= p;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(want);
        words_sent++;
    endtask

    initial
    begin : stimulus
        logic [63:0]        n64;
        logic [FIELD_W-1:0] n;
        logic [FIELD_W-1:0] k;
        logic [FIELD_W-1:0] p;
        int                 pick;

        corners = '{
            '{32'd0,        32'd0,        32'd2,        1'b1, '{6'd0, STAT_OK}},
            '{32'd5,        32'd6,        32'd3,        1'b1, '{6'd0, STAT_K_EXCEEDS_N}},
            // k above n wins over a bad divisor
            '{32'd0,        32'd1,        32'd0,        1'b1, '{6'd0, STAT_K_EXCEEDS_N}},
            '{32'd10,       32'd3,        32'd0,        1'b1, '{6'd0, STAT_BAD_DIVISOR}},
            '{32'd10,       32'd3,        32'd1,        1'b1, '{6'd0, STAT_BAD_DIVISOR}},
            '{32'd10,       32'd3,        32'd11,       1'b1, '{6'd0, STAT_OK}},
            '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'd2,        1'b1, '{6'd0, STAT_OK}},
            '{32'hFFFFFFFF, 32'd0,        32'hFFFFFFFF, 1'b0, '{6'd0, STAT_OK}},
            // 1 + 0x7fffffff carries 31 times in base two
            '{32'h80000000, 32'd1,        32'd2,        1'b0, '{6'd0, STAT_OK}},
            '{32'hFFFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1'b0, '{6'd0, STAT_OK}},
            '{32'd100,      32'd50,       32'd7,        1'b0, '{6'd0, STAT_OK}},
            '{32'd100,      32'd50,       32'd4,        1'b0, '{6'd0, STAT_OK}},
            '{32'd1000,     32'd500,      32'd3,        1'b0, '{6'd0, STAT_OK}},
            '{32'hFFFFFFFE, 32'h7FFFFFFF, 32'd3,        1'b0, '{6'd0, STAT_OK}},
            '{32'd12,       32'd4,        32'hFFFFFFFF, 1'b1, '{6'd0, STAT_OK}},
            '{32'hFFFFFFFF, 32'd1,        32'hFFFFFFFE, 1'b0, '{6'd0, STAT_OK}},
            '{32'hFFFFFFFF, 32'd1,        32'h7FFFFFFF, 1'b0, '{6'd0, STAT_OK}},
            '{32'd1,        32'd1,        32'd0,        1'b1, '{6'd0, STAT_BAD_DIVISOR}},
            '{32'd0,        32'd0,        32'd0,        1'b1, '{6'd0, STAT_BAD_DIVISOR}},
            '{32'd6,        32'd3,        32'd2,        1'b0, '{6'd0, STAT_OK}},
            '{32'h12345678, 32'h00ABCDEF, 32'd5,        1'b0, '{6'd0, STAT_OK}},
            '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0,        1'b1, '{6'd0, STAT_BAD_DIVISOR}}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corners[i])
            offer_word(corners[i].n, corners[i].k, corners[i].p,
                       corners[i].known ? corners[i].want
                                        : legendre_exponent(corners[i].n, corners[i].k,
                                                            corners[i].p));

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            // drain fully before each change of idle pattern
            if (i == RANDOM_WORDS / 3 || i == 2 * RANDOM_WORDS / 3)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (expected_results.size() != 0)
                    @(posedge clk);
                if (i == RANDOM_WORDS / 3)
                begin
                    send_idle = 84;
                    recv_idle = 13;
                end
                else
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            end

            pick = $urandom_range(0, 99);
            n    = $urandom >> $urandom_range(0, 31);
            n64  = 64'(n);
            k    = FIELD_W'({$urandom, $urandom} % (n64 + 64'd1));
            if (pick < 45)
                p = small_primes[$urandom_range(0, 7)];
            else if (pick < 60)
                p = $urandom;
            else if (pick < 70)
                p = $urandom_range(2, 1000);
            else if (pick < 80)
            begin
                if (n == '1)
                    n = n - 1;
                k = n + 1 + ($urandom % (32'hFFFFFFFF - n));
                p = $urandom;
            end
            else if (pick < 90)
                p = $urandom_range(0, 1);
            else
            begin
                n = $urandom;
                k = $urandom;
                p = $urandom;
            end
            offer_word(n, k, p, legendre_exponent(n, k, p));
        end

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            mismatches++;
        end
        $display("%0d words sent, %0d results checked: corner table, random n/k/p,",
                 words_sent, results_seen);
        $display("both-side idling, a long output hold-off and drain pauses");
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : result_side
        result_t want;
        int      hold_left;
        bit      held;
        hold_left = 0;
        held      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: exponent %0d status %0d", exponent, status);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (exponent !== want.expo)
                    begin
                        $error("exponent: expected %0d, got %0d", want.expo, exponent);
                        mismatches++;
                    end
                    if (status !== want.stat)
                    begin
                        $error("status: expected %0d, got %0d", want.stat, status);
                        mismatches++;
                    end
                end
                results_seen++;
            end
            // one long hold-off so the block backs up into its input
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (results_seen == HOLD_AT && !held)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

endmodule

>>> binomial_prime_exponent.f
src/bpe_pkg.sv
src/bpe_datapath.sv
src/bpe_ctrl.sv
src/binomial_prime_exponent.sv
test/binomial_prime_exponent_test.sv
